/* rtl/core/nbcfg_pkg.sv */
// Shared types, register offsets and reset defaults for the host bridge
// configuration space. No dependencies; used by nbcfg_wrule and the top level.
package nbcfg_pkg;

   localparam int CONFIG_SPACE_BYTES = 256;
   localparam int ADDR_W             = $clog2(CONFIG_SPACE_BYTES);

   // request opcodes
   localparam logic [2:0] OP_CFG_READ  = 3'd0;
   localparam logic [2:0] OP_CFG_WRITE = 3'd1;
   localparam logic [2:0] OP_SMM_ENTER = 3'd2;
   localparam logic [2:0] OP_SMM_EXIT  = 3'd3;
   localparam logic [2:0] OP_RESET_EVT = 3'd4;

   // register offsets
   localparam logic [ADDR_W-1:0] REG_COMMAND_LO = 8'h04;
   localparam logic [ADDR_W-1:0] REG_COMMAND_HI = 8'h05;
   localparam logic [ADDR_W-1:0] REG_STATUS_LO  = 8'h06;
   localparam logic [ADDR_W-1:0] REG_STATUS_HI  = 8'h07;
   localparam logic [ADDR_W-1:0] REG_PAM0       = 8'h59;
   localparam logic [ADDR_W-1:0] REG_PAM1       = 8'h5A;
   localparam logic [ADDR_W-1:0] REG_PAM6       = 8'h5F;
   localparam logic [ADDR_W-1:0] REG_SMRAM      = 8'h72;
   localparam logic [ADDR_W-1:0] REG_BAR_FIRST  = 8'h10;
   localparam logic [ADDR_W-1:0] REG_BAR_LAST   = 8'h4E;

   localparam logic [7:0] PAM0_RESET_VALUE = 8'h0F;

   // SMRAM control bits
   localparam int SMRAM_D_OPEN   = 3;
   localparam int SMRAM_D_LCK    = 4;
   localparam int SMRAM_GLOBAL_EN = 6;

   // memory windows
   localparam logic [19:0] BIOS_BASE     = 20'hF0000;
   localparam logic [17:0] BIOS_SIZE     = 18'h10000;
   localparam logic [19:0] OPTROM_BASE   = 20'hC0000;
   localparam logic [17:0] OPTROM_SIZE   = 18'h04000;
   localparam logic [19:0] SMRAM_BASE    = 20'hA0000;
   localparam logic [17:0] SMRAM_SIZE    = 18'h20000;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  read_data;
      logic [19:0] region_base;
      logic [17:0] region_size;
      logic        read_internal;
      logic        write_internal;
      logic        last;
   } result_type;

   // write-back and result count from the rule logic
   typedef struct packed {
      logic              store;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        value;
      logic [1:0]        n_res;
   } wr_ctl_type;

   function automatic logic [7:0] default_byte(input logic [ADDR_W-1:0] a);
      logic [7:0] d;
      d = 8'h00;
      if (a inside {[8'h60:8'h64]}) begin
         d = 8'h02;
      end else begin
         case (a)
            8'h00:   d = 8'h86;
            8'h01:   d = 8'h80;
            8'h02:   d = 8'h30;
            8'h03:   d = 8'h70;
            8'h04:   d = 8'h06;
            8'h07:   d = 8'h02;
            8'h0B:   d = 8'h06;
            8'h52:   d = 8'h42;
            8'h53:   d = 8'h14;
            8'h56:   d = 8'h52;
            8'h57:   d = 8'h01;
            8'h67:   d = 8'h11;
            8'h69:   d = 8'h03;
            8'h70:   d = 8'h20;
            8'h72:   d = 8'h02;
            8'h74:   d = 8'h0E;
            8'h78:   d = 8'h23;
            default: d = 8'h00;
         endcase
      end
      return d;
   endfunction

endpackage

/* rtl/core/northbridge_pci_config_space_core.sv */
// Host bridge PCI configuration space: 256-byte memory, PAM and SMRAM rules.
// Request capture and memory read happen on the accepting edge; rule logic and
// write-back run in the execute state, which pushes the results into the
// output queue. No new request is taken until that read-modify-write of the
// single-port configuration memory is done; a full 2-entry output queue adds stalls.
// Reset: per-entry valid bits clear at once, unwritten bytes read as defaults.
module northbridge_pci_config_space_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // opcode
   input  logic [23:0] req_tdata,   // function_number, register_address, write_data, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // result_kind
   output logic [47:0] rsp_tdata,   // read_data, region_base, region_size,
                                    // read_internal, write_internal
   output logic        rsp_tlast
);

   localparam int AW = nbcfg_pkg::ADDR_W;

   nbcfg_pkg::state_type  st_ff, st_in;
   logic [7:0]            mem [nbcfg_pkg::CONFIG_SPACE_BYTES];
   logic [nbcfg_pkg::CONFIG_SPACE_BYTES-1:0] vld_ff;
   logic [7:0]            rd_ff;
   logic                  rd_vld_ff;
   logic [2:0]            op_ff;
   logic [2:0]            fn_ff;
   logic [AW-1:0]         addr_ff;
   logic [7:0]            data_ff;

   nbcfg_pkg::result_type q_ff [2];
   logic                  head_ff;
   logic [1:0]            count_ff, count_in;

   logic                  accept;
   logic                  wr_go;
   logic                  pop;
   logic                  tail;
   logic [AW-1:0]         rd_addr;
   logic [7:0]            old_byte;
   nbcfg_pkg::wr_ctl_type ctl;
   nbcfg_pkg::result_type res0, res1;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   assign tail   = head_ff ^ count_ff[0];

   // SMM events look at the SMRAM byte, the reset event at PAM0
   always_comb begin
      case (req_tuser)
         nbcfg_pkg::OP_SMM_ENTER: rd_addr = nbcfg_pkg::REG_SMRAM;
         nbcfg_pkg::OP_SMM_EXIT:  rd_addr = nbcfg_pkg::REG_SMRAM;
         nbcfg_pkg::OP_RESET_EVT: rd_addr = nbcfg_pkg::REG_PAM0;
         default:                 rd_addr = req_tdata[10:3];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= nbcfg_pkg::ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      st_in      = st_ff;
      req_tready = 1'b0;
      wr_go      = 1'b0;
      case (st_ff)
         nbcfg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               st_in = nbcfg_pkg::ST_EXEC;
            end
         end
         nbcfg_pkg::ST_EXEC: begin
            // hold until the output queue has room for every result
            if ({1'b0, count_ff} + {1'b0, ctl.n_res} <= 3'd2) begin
               wr_go = 1'b1;
               st_in = nbcfg_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = nbcfg_pkg::ST_IDLE;
         end
      endcase
   end

   // request capture and memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_tuser;
         fn_ff     <= req_tdata[2:0];
         addr_ff   <= rd_addr;
         data_ff   <= req_tdata[18:11];
         rd_ff     <= mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_go && ctl.store) begin
         mem[ctl.addr] <= ctl.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_go && ctl.store) begin
         vld_ff[ctl.addr] <= 1'b1;
      end
   end

   assign old_byte = rd_vld_ff ? rd_ff : nbcfg_pkg::default_byte(addr_ff);

   nbcfg_wrule u_wrule (
      .op   (op_ff),
      .fn   (fn_ff),
      .addr (addr_ff),
      .data (data_ff),
      .old  (old_byte),
      .ctl  (ctl),
      .res0 (res0),
      .res1 (res1)
   );

   // output queue
   always_comb begin
      count_in = count_ff - {1'b0, pop};
      if (wr_go) begin
         count_in = count_in + ctl.n_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (pop) begin
            head_ff <= ~head_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_go && (ctl.n_res != 2'd0)) begin
         q_ff[tail] <= res0;
      end
      if (wr_go && (ctl.n_res == 2'd2)) begin
         q_ff[~tail] <= res1;
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tuser  = q_ff[head_ff].kind;
   assign rsp_tlast  = q_ff[head_ff].last;
   assign rsp_tdata  = {q_ff[head_ff].write_internal, q_ff[head_ff].read_internal,
                        q_ff[head_ff].region_size, q_ff[head_ff].region_base,
                        q_ff[head_ff].read_data};

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("output queue count out of range");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (st_ff == nbcfg_pkg::ST_EXEC))
      else $error("accepted word did not enter execute");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_go |-> ({1'b0, count_ff} + {1'b0, ctl.n_res} <= 3'd2))
      else $error("results pushed into a full queue");

   a_bar_protect: assert property (@(posedge clock) disable iff (reset)
      (wr_go && ctl.store) |->
         !((ctl.addr >= nbcfg_pkg::REG_BAR_FIRST) && (ctl.addr <= nbcfg_pkg::REG_BAR_LAST)))
      else $error("write stored into read-only range");

endmodule

/* rtl/core/nbcfg_wrule.sv */
// Write filtering and attribute-update generation for one request, given the
// old byte read from the configuration memory. Depends on nbcfg_pkg.
module nbcfg_wrule (
   input  logic [2:0]                  op,
   input  logic [2:0]                  fn,
   input  logic [nbcfg_pkg::ADDR_W-1:0] addr,
   input  logic [7:0]                  data,
   input  logic [7:0]                  old,
   output nbcfg_pkg::wr_ctl_type       ctl,
   output nbcfg_pkg::result_type       res0,
   output nbcfg_pkg::result_type       res1
);

   function automatic nbcfg_pkg::result_type upd(input logic [19:0] base,
                                                 input logic [17:0] size,
                                                 input logic [1:0]  attr);
      nbcfg_pkg::result_type r;
      r                = '0;
      r.kind           = 1'b1;
      r.region_base    = base;
      r.region_size    = size;
      r.read_internal  = attr[0];
      r.write_internal = attr[1];
      return r;
   endfunction

   logic                         do_wr;
   logic [7:0]                   wdata;
   logic [7:0]                   v;
   logic [7:0]                   diff;
   logic [2:0]                   pam_idx;
   logic [19:0]                  pam_base;
   logic                         hit0;
   logic                         hit1;
   nbcfg_pkg::result_type        c0;
   nbcfg_pkg::result_type        c1;

   always_comb begin
      do_wr    = 1'b0;
      wdata    = data;
      v        = data;
      diff     = 8'h00;
      pam_idx  = 3'd0;
      pam_base = nbcfg_pkg::OPTROM_BASE;
      hit0     = 1'b0;
      hit1     = 1'b0;
      c0       = '0;
      c1       = '0;
      ctl      = '0;
      ctl.addr = addr;

      case (op)
         nbcfg_pkg::OP_CFG_READ: begin
            hit0         = 1'b1;
            c0.read_data = (fn != 3'd0) ? 8'hFF : old;
         end
         nbcfg_pkg::OP_CFG_WRITE: begin
            do_wr = (fn == 3'd0);
         end
         nbcfg_pkg::OP_SMM_ENTER: begin
            hit0 = old[nbcfg_pkg::SMRAM_D_OPEN];
            c0   = upd(nbcfg_pkg::SMRAM_BASE, nbcfg_pkg::SMRAM_SIZE, 2'b11);
         end
         nbcfg_pkg::OP_SMM_EXIT: begin
            hit0 = old[nbcfg_pkg::SMRAM_D_OPEN];
            c0   = upd(nbcfg_pkg::SMRAM_BASE, nbcfg_pkg::SMRAM_SIZE, 2'b00);
         end
         nbcfg_pkg::OP_RESET_EVT: begin
            do_wr = 1'b1;
            wdata = nbcfg_pkg::PAM0_RESET_VALUE;
         end
         default: begin
            do_wr = 1'b0;
         end
      endcase

      if (do_wr) begin
         v         = wdata;
         ctl.store = 1'b1;
         if ((addr >= nbcfg_pkg::REG_BAR_FIRST) &&
             (addr <= nbcfg_pkg::REG_BAR_LAST)) begin
            ctl.store = 1'b0;
         end else if (addr inside {[8'h00:8'h03], [8'h08:8'h0C], 8'h0E}) begin
            ctl.store = 1'b0;
         end else if (addr >= nbcfg_pkg::REG_PAM1 && addr <= nbcfg_pkg::REG_PAM6) begin
            diff     = old ^ v;
            pam_idx  = 3'(addr - nbcfg_pkg::REG_PAM1);
            pam_base = nbcfg_pkg::OPTROM_BASE + ({17'd0, pam_idx} << 15);
            hit0     = |diff[3:0];
            hit1     = |diff[7:4];
            c0 = upd(pam_base, nbcfg_pkg::OPTROM_SIZE, v[1:0]);
            c1 = upd(pam_base + 20'h04000, nbcfg_pkg::OPTROM_SIZE, v[5:4]);
         end else begin
            case (addr)
               nbcfg_pkg::REG_COMMAND_LO: v = (wdata & 8'h02) | 8'h04;
               nbcfg_pkg::REG_COMMAND_HI: v = 8'h00;
               nbcfg_pkg::REG_STATUS_LO:  v = 8'h00;
               nbcfg_pkg::REG_STATUS_HI:  v = (wdata & 8'h80) | 8'h02;
               nbcfg_pkg::REG_PAM0: begin
                  diff = old ^ v;
                  hit1 = |diff[7:4];
                  c1   = upd(nbcfg_pkg::BIOS_BASE, nbcfg_pkg::BIOS_SIZE, v[5:4]);
               end
               nbcfg_pkg::REG_SMRAM: begin
                  // lock is sticky; once locked, D_OPEN drops and the global enable holds
                  v = (wdata & 8'h78) | 8'h02 | (old & 8'h10);
                  if (v[nbcfg_pkg::SMRAM_D_LCK]) begin
                     v = (v & 8'hB7) | (old & 8'h40);
                  end
                  hit0 = old[nbcfg_pkg::SMRAM_GLOBAL_EN] ^ v[nbcfg_pkg::SMRAM_GLOBAL_EN];
                  c0   = upd(nbcfg_pkg::SMRAM_BASE, nbcfg_pkg::SMRAM_SIZE,
                             {2{v[nbcfg_pkg::SMRAM_GLOBAL_EN]}});
               end
               default: v = wdata;
            endcase
         end
      end

      ctl.value = v;
      ctl.n_res = {1'b0, hit0} + {1'b0, hit1};
   end

   // compact candidates so results fill from slot 0 and mark the final one
   always_comb begin
      res0      = hit0 ? c0 : c1;
      res1      = c1;
      res0.last = (ctl.n_res == 2'd1);
      res1.last = 1'b1;
   end

endmodule
